FILE: sv/skst_pkg.sv
// skst_pkg: shared types, constants and helpers for the sorted key set table.
// No dependencies; compiled first.
package skst_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 32;
    localparam int OPCODE_W  = 2;
    localparam int OUT_CNT_W = 7;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [OPCODE_W-1:0]     opcode_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic [OUT_CNT_W-1:0]    out_count_t;

    localparam opcode_t OP_MEMBER = 2'd0;
    localparam opcode_t OP_INSERT = 2'd1;
    localparam opcode_t OP_DELETE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Row-wide command for every cell
    typedef struct packed {
        logic cmp_en;
        logic do_ins;
        logic do_del;
    } cell_ctl_t;

    // Count as reported on the response: the low OUT_CNT_W bits, which hold the whole count
    function automatic out_count_t to_out_count(input count_t c);
        logic [CNT_W+OUT_CNT_W-1:0] wide;
        begin
            wide = (CNT_W + OUT_CNT_W)'(c);
            return wide[OUT_CNT_W-1:0];
        end
    endfunction

endpackage

FILE: sv/skst_if.sv
// skst_req_if / skst_rsp_if: valid/ready channels for requests and responses.
// Depends on skst_pkg.
interface skst_req_if;
    import skst_pkg::*;
    logic    valid;
    logic    ready;
    opcode_t opcode;
    key_t    key;
    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface skst_rsp_if;
    import skst_pkg::*;
    logic       valid;
    logic       ready;
    logic       success;
    logic       full_reject;
    out_count_t entry_count;
    modport source (output valid, output success, output full_reject,
                    output entry_count, input ready);
    modport sink   (input valid, input success, input full_reject,
                    input entry_count, output ready);
endinterface

FILE: sv/skst_cell.sv
// skst_cell: one slot of the sorted row; compares against the broadcast key
// and shifts toward either neighbor on insert or delete. Depends on skst_pkg.
module skst_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  skst_pkg::cell_ctl_t ctl,
    input  skst_pkg::key_t      bcast_key,
    input  logic                slot_valid,
    input  skst_pkg::key_t      left_key,
    input  logic                left_lt,
    input  skst_pkg::key_t      right_key,
    output skst_pkg::key_t      key_out,
    output logic                lt_out,
    output logic                eq_out
);
    import skst_pkg::*;

    key_t key_reg, key_next;
    logic lt_reg, lt_next;
    logic eq_reg, eq_next;

    // Compare flags, captured on the request's first cycle
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctl.cmp_en)
        begin
            lt_next = slot_valid && (key_reg < bcast_key);
            eq_next = slot_valid && (key_reg == bcast_key);
        end
    end

    // Shift: slots below the insert/delete point keep their key
    always_comb
    begin
        key_next = key_reg;
        if (ctl.do_ins && !lt_reg)
        begin
            key_next = left_lt ? bcast_key : left_key;
        end
        else if (ctl.do_del && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // Key storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

FILE: sv/sorted_key_set_table_core.sv
// Each request runs a compare step across the cell row, then an update step in
// which the row shifts and the response loads; the update waits while an earlier
// response is still held, and no new request is accepted until it is done.
// The response register lets the next request start while a response waits.
// Reset clears the entry count, the compare flags and the handshake state;
// key storage is not cleared, slots at or above the count are never read.
module sorted_key_set_table_core (
    input  logic clk,
    input  logic rst_n,
    skst_req_if.sink   req,
    skst_rsp_if.source rsp
);
    import skst_pkg::*;

    state_t     state_reg, state_next;
    key_t       key_reg, key_next;
    opcode_t    op_reg, op_next;
    count_t     count_reg, count_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       success_reg, success_next;
    logic       full_reg, full_next;
    out_count_t rsp_count_reg, rsp_count_next;

    cell_ctl_t         ctl;
    key_t              bcast_key;
    key_t              cell_key [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] slot_valid;
    logic              present;
    logic              req_fire;
    logic              rsp_slot_free;

    assign req_fire      = req.valid && req.ready;
    assign rsp_slot_free = !rsp_valid_reg || rsp.ready;
    assign present       = |eq_vec;
    assign bcast_key     = (state_reg == ST_IDLE) ? req.key : key_reg;

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t left_key_w;
        logic left_lt_w;
        key_t right_key_w;

        assign slot_valid[i] = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign left_key_w = bcast_key;
            assign left_lt_w  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key_w = cell_key[i-1];
            assign left_lt_w  = lt_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key_w = cell_key[i];
        end
        else
        begin : g_inner
            assign right_key_w = cell_key[i+1];
        end

        skst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .bcast_key  (bcast_key),
            .slot_valid (slot_valid[i]),
            .left_key   (left_key_w),
            .left_lt    (left_lt_w),
            .right_key  (right_key_w),
            .key_out    (cell_key[i]),
            .lt_out     (lt_vec[i]),
            .eq_out     (eq_vec[i])
        );
    end

    // Sequencer: compare on accept, update and respond in the next state
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        success_next   = success_reg;
        full_next      = full_reg;
        rsp_count_next = rsp_count_reg;
        ctl            = '0;
        req.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    ctl.cmp_en = 1'b1;
                    key_next   = req.key;
                    op_next    = req.opcode;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (rsp_slot_free)
                begin
                    success_next = 1'b0;
                    full_next    = 1'b0;
                    case (op_reg)
                        OP_MEMBER:
                        begin
                            success_next = present;
                        end
                        OP_INSERT:
                        begin
                            if (!present)
                            begin
                                if (count_reg >= CNT_W'(CAPACITY))
                                begin
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    ctl.do_ins   = 1'b1;
                                    count_next   = count_reg + 1'b1;
                                    success_next = 1'b1;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (present)
                            begin
                                ctl.do_del   = 1'b1;
                                count_next   = count_reg - 1'b1;
                                success_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            success_next = 1'b0;
                        end
                    endcase
                    rsp_count_next = to_out_count(count_next);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        op_reg        <= op_next;
        success_reg   <= success_next;
        full_reg      <= full_next;
        rsp_count_reg <= rsp_count_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.success     = success_reg;
    assign rsp.full_reject = full_reg;
    assign rsp.entry_count = rsp_count_reg;

`ifndef SYNTHESIS
    // Count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted request is always followed by the update state
    a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == ST_APPLY)
        else $error("accepted request did not move to update");

    // Below-key flags form a prefix of the sorted row
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (lt_vec & (lt_vec + CAPACITY'(1))) == '0)
        else $error("compare flags not a prefix, table unsorted");

    // The count only moves when a response is produced
    a_count_with_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> rsp_valid_reg)
        else $error("count changed without a response");
`endif

endmodule
